[design/pgd_pkg.sv]
// shared types and constants for the particle grid dimensioner
// no dependencies; imported by every module of the block
package pgd_pkg;

  localparam int unsigned MAX_PARTICLES_DEF = 1048576;

  localparam int unsigned ID_W    = 20;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned RAD_W   = 31;
  localparam int unsigned FACT_W  = 16;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned PROD_W  = FACT_W + RAD_W;
  localparam int unsigned BIN_W   = PROD_W - FRAC_W;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned CFG_A_W = 1;
  localparam int unsigned CFG_D_W = 20;

  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [FACT_W-1:0] BIN_FACTOR_RST   = 16'd5325;
  localparam logic [ID_W-1:0]   MIN_FLUID_ID_RST = 20'd4;
  localparam logic [CELL_W-1:0] CELL_MAX         = 16'hffff;
  localparam logic [CELL_W-1:0] CELL_MIN         = 16'd1;

  localparam logic [CFG_A_W-1:0] REG_BIN_FACTOR   = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_MIN_FLUID_ID = 1'd1;

  typedef struct packed {
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
  } axis_span_t;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_JZ_CNT,
    OP_DIV,
    OP_MUL,
    OP_JZ_BIN,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    SRC_MEAN,
    SRC_X,
    SRC_Y,
    SRC_Z
  } src_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_X,
    DST_Y,
    DST_Z
  } dst_t;

  typedef struct packed {
    op_t              op;
    src_t             src;
    dst_t             dst;
    logic             degen;
    logic [STEP_W-1:0] target;
  } ctrl_t;

endpackage

[design/pgd_accum.sv]
// per-set accumulator: axis extremes, radius sum and fluid count
// depends on pgd_pkg
module pgd_accum import pgd_pkg::*; #(
  parameter int unsigned MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int unsigned CNT_W         = $clog2(MAX_PARTICLES + 1),
  parameter int unsigned SUM_W         = CNT_W + RAD_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    take,
  input  logic                    clear,
  input  logic [ID_W-1:0]         min_fluid_id,
  input  logic [ID_W-1:0]         particle_id,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [RAD_W-1:0]        smoothing_radius,
  output axis_span_t              span_x,
  output axis_span_t              span_y,
  output axis_span_t              span_z,
  output logic [SUM_W-1:0]        radius_total,
  output logic [CNT_W-1:0]        fluid_count
);

  axis_span_t        sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              first_r, first_nxt;
  logic              fluid;

  function automatic axis_span_t widen(axis_span_t s, logic signed [POS_W-1:0] v,
                                       logic seed, logic upd);
    axis_span_t r;
    r = seed ? '{lo: v, hi: v} : s;
    if (upd) begin
      if (v > r.hi) r.hi = v;
      if (v < r.lo) r.lo = v;
    end
    return r;
  endfunction

  assign fluid = particle_id >= min_fluid_id;

  always_comb begin
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sz_nxt    = sz_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    if (clear) begin
      sx_nxt    = '0;
      sy_nxt    = '0;
      sz_nxt    = '0;
      sum_nxt   = '0;
      cnt_nxt   = '0;
      first_nxt = 1'b1;
    end else if (take) begin
      sx_nxt    = widen(sx_r, pos_x, first_r, fluid);
      sy_nxt    = widen(sy_r, pos_y, first_r, fluid);
      sz_nxt    = widen(sz_r, pos_z, first_r, fluid);
      first_nxt = 1'b0;
      if (fluid && (cnt_r < CNT_W'(MAX_PARTICLES))) begin
        sum_nxt = sum_r + SUM_W'(smoothing_radius);
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r    <= '0;
      sy_r    <= '0;
      sz_r    <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      first_r <= 1'b1;
    end else begin
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      sz_r    <= sz_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
    end
  end

  assign span_x       = sx_r;
  assign span_y       = sy_r;
  assign span_z       = sz_r;
  assign radius_total = sum_r;
  assign fluid_count  = cnt_r;

endmodule

[design/pgd_div.sv]
// restoring divider, one quotient bit per cycle
// depends on pgd_pkg
module pgd_div import pgd_pkg::*; #(
  parameter int unsigned DVD_W = 52
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [BIN_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [BIN_W-1:0] rem_r, rem_nxt;
  logic [BIN_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [BIN_W:0]   trial;
  logic [BIN_W:0]   diff;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(DVD_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[BIN_W]) begin
        rem_nxt = diff[BIN_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[BIN_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[design/pgd_seq.sv]
// microcoded sequencer: program rom, step counter, bin and cell datapath, result register
// depends on pgd_pkg; drives pgd_div and clears pgd_accum
module pgd_seq import pgd_pkg::*; #(
  parameter int unsigned CNT_W = 21,
  parameter int unsigned SUM_W = CNT_W + RAD_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  logic              in_last,
  output logic              in_ready,
  output logic              acc_clear,
  input  axis_span_t        span_x,
  input  axis_span_t        span_y,
  input  axis_span_t        span_z,
  input  logic [SUM_W-1:0]  radius_total,
  input  logic [CNT_W-1:0]  fluid_count,
  input  logic [FACT_W-1:0] bin_factor,
  output logic              div_start,
  output logic [SUM_W-1:0]  div_dividend,
  output logic [BIN_W-1:0]  div_divisor,
  input  logic              div_done,
  input  logic [SUM_W-1:0]  div_quotient,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] cells_x,
  output logic [CELL_W-1:0] cells_y,
  output logic [CELL_W-1:0] cells_z,
  output logic              degenerate
);

  localparam logic [STEP_W-1:0] L_ACCEPT = 4'd0;
  localparam logic [STEP_W-1:0] L_DEGEN  = 4'd9;

  function automatic ctrl_t rom(logic [STEP_W-1:0] s);
    ctrl_t c;
    c = '{op: OP_ACCEPT, src: SRC_MEAN, dst: DST_NONE, degen: 1'b0, target: L_ACCEPT};
    unique case (s)
      4'd0: c.op = OP_ACCEPT;
      4'd1: begin
        c.op     = OP_JZ_CNT;
        c.target = L_DEGEN;
      end
      4'd2: c.op = OP_DIV;
      4'd3: c.op = OP_MUL;
      4'd4: begin
        c.op     = OP_JZ_BIN;
        c.target = L_DEGEN;
      end
      4'd5: begin
        c.op  = OP_DIV;
        c.src = SRC_X;
        c.dst = DST_X;
      end
      4'd6: begin
        c.op  = OP_DIV;
        c.src = SRC_Y;
        c.dst = DST_Y;
      end
      4'd7: begin
        c.op  = OP_DIV;
        c.src = SRC_Z;
        c.dst = DST_Z;
      end
      4'd8: c.op = OP_EMIT;
      4'd9: begin
        c.op    = OP_EMIT;
        c.degen = 1'b1;
      end
      default: c.op = OP_ACCEPT;
    endcase
    return c;
  endfunction

  function automatic logic [POS_W-1:0] width_of(axis_span_t s);
    logic signed [POS_W:0] d;
    d = {s.hi[POS_W-1], s.hi} - {s.lo[POS_W-1], s.lo};
    return d[POS_W-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] clamp(logic [SUM_W-1:0] q);
    if (|q[SUM_W-1:CELL_W]) return CELL_MAX;
    if (q[CELL_W-1:0] == '0) return CELL_MIN;
    return q[CELL_W-1:0];
  endfunction

  ctrl_t             cw;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic [BIN_W-1:0]  bin_r, bin_nxt;
  logic [CELL_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic              ov_r, ov_nxt;
  logic [CELL_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic              od_r, od_nxt;
  logic [PROD_W-1:0] prod;
  logic              slot_free;

  assign cw        = rom(step_r);
  assign slot_free = !ov_r || out_ready;
  assign prod      = {{RAD_W{1'b0}}, bin_factor} * {{FACT_W{1'b0}}, div_quotient[RAD_W-1:0]};

  always_comb begin
    case (cw.src)
      SRC_X:   div_dividend = SUM_W'(width_of(span_x));
      SRC_Y:   div_dividend = SUM_W'(width_of(span_y));
      SRC_Z:   div_dividend = SUM_W'(width_of(span_z));
      default: div_dividend = radius_total;
    endcase
    div_divisor = (cw.src == SRC_MEAN) ? BIN_W'(fluid_count) : bin_r;
  end

  always_comb begin
    step_nxt  = step_r;
    busy_nxt  = busy_r;
    bin_nxt   = bin_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    ov_nxt    = ov_r && !out_ready;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oz_nxt    = oz_r;
    od_nxt    = od_r;
    in_ready  = 1'b0;
    acc_clear = 1'b0;
    div_start = 1'b0;
    unique case (cw.op)
      OP_ACCEPT: begin
        in_ready = 1'b1;
        if (in_take && in_last) step_nxt = step_r + STEP_W'(1);
      end
      OP_JZ_CNT: begin
        step_nxt = (fluid_count == '0) ? cw.target : step_r + STEP_W'(1);
      end
      OP_DIV: begin
        if (!busy_r) begin
          div_start = 1'b1;
          busy_nxt  = 1'b1;
        end else if (div_done) begin
          busy_nxt = 1'b0;
          step_nxt = step_r + STEP_W'(1);
          case (cw.dst)
            DST_X:   cx_nxt = clamp(div_quotient);
            DST_Y:   cy_nxt = clamp(div_quotient);
            DST_Z:   cz_nxt = clamp(div_quotient);
            default: ;
          endcase
        end
      end
      OP_MUL: begin
        bin_nxt  = prod[PROD_W-1:FRAC_W];
        step_nxt = step_r + STEP_W'(1);
      end
      OP_JZ_BIN: begin
        step_nxt = (bin_r == '0) ? cw.target : step_r + STEP_W'(1);
      end
      OP_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ox_nxt    = cw.degen ? CELL_MIN : cx_r;
          oy_nxt    = cw.degen ? CELL_MIN : cy_r;
          oz_nxt    = cw.degen ? CELL_MIN : cz_r;
          od_nxt    = cw.degen;
          acc_clear = 1'b1;
          step_nxt  = cw.target;
        end
      end
      default: step_nxt = L_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= L_ACCEPT;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    bin_r <= bin_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    cz_r  <= cz_nxt;
    ox_r  <= ox_nxt;
    oy_r  <= oy_nxt;
    oz_r  <= oz_nxt;
    od_r  <= od_nxt;
  end

  assign out_valid  = ov_r;
  assign cells_x    = ox_r;
  assign cells_y    = oy_r;
  assign cells_z    = oz_r;
  assign degenerate = od_r;

endmodule

[design/particle_grid_dimensioner.sv]
// particle grid dimensioner: sizes a uniform 3-d search grid from a particle set
// usage: in_ carries one particle per transfer, in_tlast marks the last particle of a set;
// out_ carries one result per set: cells per axis in tdata, the degenerate flag in tuser.
// cfg_ writes bin_factor (index 0, unsigned q4.12) and min_fluid_id (index 1) only while
// idle: the user must keep to this, the block does not enforce it. loading takes one
// particle per cycle while in_tready is high; each accepted fluid particle updates axis
// extremes (seeded by the first particle), radius sum and fluid count in the same cycle.
// after the last particle a small microprogram runs one shared 1-bit-per-cycle divider up
// to four times (mean radius, then x, y, z cell counts), dividend width SUM_W =
// clog2(MAX_PARTICLES+1) + 31; a set with no fluid particle skips the divider and one with
// a zero bin size stops after the mean radius. in_tready is low while the program runs.
// the result sits in an output register: the next set loads while it waits for
// out_tready, and a stalled receiver holds the block only when a second result is ready.
// reset (rst_n low, synchronous) restores the register defaults, empties the set
// and drops out_tvalid.
// depends on pgd_pkg, pgd_accum, pgd_div, pgd_seq
module particle_grid_dimensioner import pgd_pkg::*; #(
  parameter int unsigned MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // particle_id[19:0], pos_x[51:20], pos_y[83:52], pos_z[115:84],
  // smoothing_radius[146:116], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cells_x[15:0], cells_y[31:16], cells_z[47:32]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // degenerate[0]
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_D_W-1:0]    cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned SUM_W = CNT_W + RAD_W;

  logic [FACT_W-1:0] bin_factor_r, bin_factor_nxt;
  logic [ID_W-1:0]   min_fluid_id_r, min_fluid_id_nxt;

  logic              take;
  logic              acc_clear;
  axis_span_t        span_x, span_y, span_z;
  logic [SUM_W-1:0]  radius_total;
  logic [CNT_W-1:0]  fluid_count;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_dividend, div_quotient;
  logic [BIN_W-1:0]  div_divisor;
  logic [CELL_W-1:0] cells_x, cells_y, cells_z;

  always_comb begin
    bin_factor_nxt   = bin_factor_r;
    min_fluid_id_nxt = min_fluid_id_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_BIN_FACTOR:   bin_factor_nxt   = cfg_wdata[FACT_W-1:0];
        REG_MIN_FLUID_ID: min_fluid_id_nxt = cfg_wdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_factor_r   <= BIN_FACTOR_RST;
      min_fluid_id_r <= MIN_FLUID_ID_RST;
    end else begin
      bin_factor_r   <= bin_factor_nxt;
      min_fluid_id_r <= min_fluid_id_nxt;
    end
  end

  assign take = in_tvalid && in_tready;

  pgd_accum #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W)
  ) u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take),
    .clear           (acc_clear),
    .min_fluid_id    (min_fluid_id_r),
    .particle_id     (in_tdata[19:0]),
    .pos_x           (in_tdata[51:20]),
    .pos_y           (in_tdata[83:52]),
    .pos_z           (in_tdata[115:84]),
    .smoothing_radius(in_tdata[146:116]),
    .span_x          (span_x),
    .span_y          (span_y),
    .span_z          (span_z),
    .radius_total    (radius_total),
    .fluid_count     (fluid_count)
  );

  pgd_div #(
    .DVD_W(SUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quotient)
  );

  pgd_seq #(
    .CNT_W(CNT_W),
    .SUM_W(SUM_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (take),
    .in_last     (in_tlast),
    .in_ready    (in_tready),
    .acc_clear   (acc_clear),
    .span_x      (span_x),
    .span_y      (span_y),
    .span_z      (span_z),
    .radius_total(radius_total),
    .fluid_count (fluid_count),
    .bin_factor  (bin_factor_r),
    .div_start   (div_start),
    .div_dividend(div_dividend),
    .div_divisor (div_divisor),
    .div_done    (div_done),
    .div_quotient(div_quotient),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .cells_x     (cells_x),
    .cells_y     (cells_y),
    .cells_z     (cells_z),
    .degenerate  (out_tuser)
  );

  assign out_tdata = {cells_z, cells_y, cells_x};

endmodule
